[design/set_assoc_cache_lru_write_policy_unit_macros.svh]
// Assertion macros shared by the cache tag unit.
`ifndef SET_ASSOC_CACHE_LRU_WRITE_POLICY_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_WRITE_POLICY_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SACL_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sacl_pkg.sv]
// Types, codes and defaults shared by the cache tag unit.
package sacl_pkg;

	localparam int SETS_DEF      = 256;
	localparam int WAYS_DEF      = 8;
	localparam int ADDR_BITS_DEF = 32;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int WAY_OUT_W   = 3;
	localparam int REFS_W      = 2;
	localparam int NWAYS_W     = 5;

	localparam logic [4:0] OFFSET_BITS_RST  = 5'd4;
	localparam logic [3:0] INDEX_BITS_RST   = 4'd8;
	localparam logic [3:0] WAYS_IN_USE_RST  = 4'd8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_OFFSET_BITS,
		CFG_INDEX_BITS,
		CFG_WAYS_IN_USE,
		CFG_WRITE_POLICY
	} cfg_index_t;

	typedef enum logic {
		CMD_READ,
		CMD_WRITE
	} cmd_t;

	typedef enum logic {
		WP_THROUGH,
		WP_BACK
	} policy_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL
	} state_t;

	typedef struct packed {
		cmd_t                 cmd;
		policy_t              policy;
		logic [NWAYS_W-1:0]   nways;
	} ctl_t;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic                 dirty_evict;
		logic [REFS_W-1:0]    mem_refs;
	} rsp_t;

endpackage

[design/sacl_if.sv]
// Request, response and configuration channel interfaces of the cache tag unit.
interface sacl_req_if #(parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF);
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [ADDR_BITS-1:0] address;

	modport source (output valid, output cmd, output address, input ready);
	modport sink (input valid, input cmd, input address, output ready);
endinterface

interface sacl_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                hit;
	logic [sacl_pkg::WAY_OUT_W-1:0]      way;
	logic                                dirty_evict;
	logic [sacl_pkg::REFS_W-1:0]         mem_refs;

	modport source (output valid, output hit, output way, output dirty_evict,
		output mem_refs, input ready);
	modport sink (input valid, input hit, input way, input dirty_evict,
		input mem_refs, output ready);
endinterface

interface sacl_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [sacl_pkg::CFG_INDEX_W-1:0]    index;
	logic [sacl_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/sacl_ram.sv]
// Simple dual-port synchronous memory with a registered read port.
module sacl_ram #(
	parameter int DEPTH = sacl_pkg::SETS_DEF,
	parameter int AW    = 8,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// The read data holds while no read is issued, so a stalled lookup keeps its row.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/sacl_lookup.sv]
// Tag match, victim choice, recency update and response for one set row.
module sacl_lookup #(
	parameter int WAYS      = sacl_pkg::WAYS_DEF,
	parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF,
	parameter int WB        = (WAYS > 1) ? $clog2(WAYS) : 1,
	parameter int MW        = WAYS * (2 + WB)
) (
	input  sacl_pkg::ctl_t            ctl,
	input  logic [ADDR_BITS-1:0]      tag,
	input  logic [MW-1:0]             meta_row,
	input  logic [WAYS*ADDR_BITS-1:0] tag_row,
	output logic [MW-1:0]             meta_new,
	output logic [WAYS*ADDR_BITS-1:0] tag_new,
	output sacl_pkg::rsp_t            res
);
	import sacl_pkg::*;

	logic [WAYS-1:0]      valid;
	logic [WAYS-1:0]      dirty;
	logic [WB-1:0]        rank [WAYS];
	logic [ADDR_BITS-1:0] tags [WAYS];
	logic [WAYS-1:0]      valid_n;
	logic [WAYS-1:0]      dirty_n;
	logic [WB-1:0]        rank_n [WAYS];
	logic [ADDR_BITS-1:0] tags_n [WAYS];
	logic                 hit;
	logic [WB-1:0]        hit_way;
	logic                 free;
	logic [WB-1:0]        free_way;
	logic [WB-1:0]        lru_way;
	logic [WB-1:0]        lru_rank;
	logic                 fill;
	logic                 evict;
	logic [WB-1:0]        tw;
	logic [WB-1:0]        tw_rank;
	logic                 is_wr;
	logic                 wb_mode;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			valid[w] = meta_row[w];
			dirty[w] = meta_row[WAYS + w];
			rank[w]  = meta_row[2*WAYS + w*WB +: WB];
			tags[w]  = tag_row[w*ADDR_BITS +: ADDR_BITS];
		end
	end

	always_comb begin
		is_wr   = (ctl.cmd == CMD_WRITE);
		wb_mode = (ctl.policy == WP_BACK);

		// Scanning downward leaves the lowest matching way selected.
		hit      = 1'b0;
		hit_way  = '0;
		free     = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (w < ctl.nways && valid[w] && tags[w] == tag) begin
				hit     = 1'b1;
				hit_way = WB'(w);
			end
			if (w < ctl.nways && !valid[w]) begin
				free     = 1'b1;
				free_way = WB'(w);
			end
		end

		// Strict compare keeps the lowest numbered way among equal ranks.
		lru_way  = '0;
		lru_rank = rank[0];
		for (int v = 1; v < WAYS; v++) begin
			if (v < ctl.nways && rank[v] < lru_rank) begin
				lru_way  = WB'(v);
				lru_rank = rank[v];
			end
		end

		fill  = !hit && (wb_mode || !is_wr);
		evict = wb_mode && !hit && !free && dirty[lru_way];
		if (hit) begin
			tw = hit_way;
		end else if (fill) begin
			tw = free ? free_way : lru_way;
		end else begin
			tw = '0;
		end
		tw_rank = rank[tw];

		for (int v = 0; v < WAYS; v++) begin
			valid_n[v] = valid[v];
			dirty_n[v] = dirty[v];
			tags_n[v]  = tags[v];
			rank_n[v]  = rank[v];
			if (hit || fill) begin
				if (WB'(v) == tw) begin
					rank_n[v] = WB'(WAYS - 1);
				end else if (rank[v] > tw_rank) begin
					rank_n[v] = rank[v] - WB'(1);
				end
			end
		end
		if (fill) begin
			valid_n[tw] = 1'b1;
			dirty_n[tw] = wb_mode && is_wr;
			tags_n[tw]  = tag;
		end else if (hit && wb_mode && is_wr) begin
			dirty_n[tw] = 1'b1;
		end

		res.hit         = hit;
		res.way         = WAY_OUT_W'(tw);
		res.dirty_evict = evict;
		if (!wb_mode) begin
			res.mem_refs = (hit && !is_wr) ? 2'd0 : 2'd1;
		end else if (hit) begin
			res.mem_refs = 2'd0;
		end else begin
			res.mem_refs = evict ? 2'd2 : 2'd1;
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			meta_new[w]                    = valid_n[w];
			meta_new[WAYS + w]             = dirty_n[w];
			meta_new[2*WAYS + w*WB +: WB]  = rank_n[w];
			tag_new[w*ADDR_BITS +: ADDR_BITS] = tags_n[w];
		end
	end

endmodule

[design/set_assoc_cache_lru_write_policy_unit.sv]
// Top level of the set-associative cache tag unit with LRU replacement.
// Tag-only set-associative cache with per-set recency ranks and a selectable
// write-through or write-back policy. After reset a clearing pass zeroes the
// valid, dirty and rank memory, one set per cycle, and no request is taken
// meanwhile; configuration writes are taken at any time. In the cycle a request
// is accepted its set row is read from the metadata and tag memories; then, in
// the evaluate state, the row is matched, updated, written back and the response
// is loaded into the output register. The next request is accepted in the cycle
// after that write-back, so no new request is taken before the read-modify-write
// of the set row is done. A response that waits in the output register holds
// the lookup of the following request until it is taken.
// SETS must be a power of two.
module set_assoc_cache_lru_write_policy_unit #(
	parameter int SETS      = sacl_pkg::SETS_DEF,
	parameter int WAYS      = sacl_pkg::WAYS_DEF,
	parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sacl_req_if.sink    req,
	sacl_rsp_if.source  rsp,
	sacl_cfg_if.sink    cfg
);
	import sacl_pkg::*;

	`include "set_assoc_cache_lru_write_policy_unit_macros.svh"

	localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WB       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MW       = WAYS * (2 + WB);
	localparam int TW       = WAYS * ADDR_BITS;
	localparam logic [SET_BITS-1:0] SET_MASK = SET_BITS'(SETS - 1);

	state_t                state_q;
	state_t                state_n;
	logic [SET_BITS-1:0]   clr_q;
	logic [4:0]            off_q;
	logic [3:0]            ib_q;
	logic [3:0]            ways_q;
	policy_t               pol_q;
	logic [SET_BITS-1:0]   set_q;
	logic [ADDR_BITS-1:0]  tag_q;
	cmd_t                  cmd_q;
	logic                  out_valid_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic                  done;
	logic [5:0]            tag_shift;
	logic [ADDR_BITS-1:0]  set_full;
	logic [SET_BITS-1:0]   set_in;
	logic [ADDR_BITS-1:0]  tag_in;
	logic [NWAYS_W-1:0]    nways;
	ctl_t                  ctl;
	logic                  meta_we;
	logic [SET_BITS-1:0]   meta_waddr;
	logic [MW-1:0]         meta_wdata;
	logic [MW-1:0]         meta_row;
	logic [TW-1:0]         tag_row;
	logic [MW-1:0]         meta_new;
	logic [TW-1:0]         tag_new;
	rsp_t                  res;

	// Address split: a shift past the address width leaves a zero tag.
	always_comb begin
		tag_shift = {1'b0, off_q} + {2'b00, ib_q};
		set_full  = (req.address >> off_q) & ((ADDR_BITS'(1) << ib_q) - ADDR_BITS'(1));
		set_in    = SET_BITS'(set_full) & SET_MASK;
		tag_in    = req.address >> tag_shift;
	end

	always_comb begin
		if (ways_q == 4'd0) begin
			nways = NWAYS_W'(1);
		end else if (ways_q > WAYS) begin
			nways = NWAYS_W'(WAYS);
		end else begin
			nways = NWAYS_W'(ways_q);
		end
		ctl.cmd    = cmd_q;
		ctl.policy = pol_q;
		ctl.nways  = nways;
	end

	always_comb begin
		state_n    = state_q;
		req.ready  = 1'b0;
		done       = 1'b0;
		meta_we    = 1'b0;
		meta_waddr = set_q;
		meta_wdata = meta_new;
		case (state_q)
			ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
				meta_wdata = '0;
				if (clr_q == SET_BITS'(SETS - 1)) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_n = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!out_valid_q || rsp.ready) begin
					done    = 1'b1;
					meta_we = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + SET_BITS'(1);
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= OFFSET_BITS_RST;
			ib_q   <= INDEX_BITS_RST;
			ways_q <= WAYS_IN_USE_RST;
			pol_q  <= WP_THROUGH;
		end else if (cfg.valid) begin
			case (cfg_index_t'(cfg.index))
				CFG_OFFSET_BITS:  off_q  <= cfg.data[4:0];
				CFG_INDEX_BITS:   ib_q   <= cfg.data[3:0];
				CFG_WAYS_IN_USE:  ways_q <= cfg.data[3:0];
				CFG_WRITE_POLICY: pol_q  <= policy_t'(cfg.data[0]);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_q <= set_in;
			tag_q <= tag_in;
			cmd_q <= cmd_t'(req.cmd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = rsp_q.hit;
	assign rsp.way         = rsp_q.way;
	assign rsp.dirty_evict = rsp_q.dirty_evict;
	assign rsp.mem_refs    = rsp_q.mem_refs;

	sacl_ram #(
		.DEPTH (SETS),
		.AW    (SET_BITS),
		.DW    (MW)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (accept),
		.raddr (set_in),
		.rdata (meta_row)
	);

	sacl_ram #(
		.DEPTH (SETS),
		.AW    (SET_BITS),
		.DW    (TW)
	) u_tag_ram (
		.clk   (clk),
		.we    (done),
		.waddr (set_q),
		.wdata (tag_new),
		.re    (accept),
		.raddr (set_in),
		.rdata (tag_row)
	);

	sacl_lookup #(
		.WAYS      (WAYS),
		.ADDR_BITS (ADDR_BITS),
		.WB        (WB),
		.MW        (MW)
	) u_lookup (
		.ctl      (ctl),
		.tag      (tag_q),
		.meta_row (meta_row),
		.tag_row  (tag_row),
		.meta_new (meta_new),
		.tag_new  (tag_new),
		.res      (res)
	);

	`SACL_ASSERT(a_no_req_in_clear, state_q == ST_CLEAR, !req.ready, "request taken during clear")
	`SACL_ASSERT_NEXT(a_accept_to_eval, req.valid && req.ready, state_q == ST_EVAL, "lookup lost")
	`SACL_ASSERT(a_refs_evict, rsp.valid, (rsp.mem_refs == 2'd2) == rsp.dirty_evict, "refs mismatch")
	`SACL_ASSERT(a_hit_clean, rsp.valid && rsp.hit, !rsp.dirty_evict && rsp.mem_refs != 2'd2, "hit evicted")

endmodule
